// ----- sv/imgup2x_pkg.sv -----
// ----------------------------------------------------------------------------
// imgup2x_pkg
// Shared types, widths and the per-channel mean used by the 2x upscaler.
// ----------------------------------------------------------------------------
package imgup2x_pkg;

    localparam int CHAN_W      = 8;
    localparam int COORD_W     = 11;
    localparam int CFG_W       = 11;
    localparam int CFG_WIDE_W  = 13;
    localparam int WIDTH_RST   = 1024;
    localparam int SLOT_N      = 4;

    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

    typedef struct packed {
        rgb_t   px;
        rgb_t   left;
        rgb_t   above_left;
        rgb_t   above;
        coord_t row2;
        coord_t col2;
        logic   has_above;
        logic   has_left;
    } item_t;

    function automatic chan_t mean_chan(input chan_t a, input chan_t b);
        logic [CHAN_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CHAN_W:1];
    endfunction

    function automatic rgb_t mean_rgb(input rgb_t a, input rgb_t b);
        rgb_t res;
        res.red   = mean_chan(a.red, b.red);
        res.green = mean_chan(a.green, b.green);
        res.blue  = mean_chan(a.blue, b.blue);
        return res;
    endfunction

endpackage

// ----- sv/imgup2x_interp.sv -----
// ----------------------------------------------------------------------------
// imgup2x_interp
// Forms the interpolated pixels of one input item and sends its writes one
// per cycle, while m_axis is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module imgup2x_interp
    import imgup2x_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  item_t       in_item,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    logic [SLOT_N-1:0] mask_reg, mask_next, new_mask, low_bit;
    rgb_t              corner_reg, vert_reg, horiz_reg, orig_reg;
    coord_t            row2_reg, col2_reg;
    logic              out_valid_reg;
    coord_t            out_row_reg, out_col_reg;
    rgb_t              out_px_reg;
    logic              out_last_reg;
    logic              out_load, emit, last_slot, take;
    coord_t            sel_row, sel_col;
    rgb_t              sel_px, horiz_mean;

    assign out_load  = !out_valid_reg || m_axis_tready;
    assign emit      = (mask_reg != '0) && out_load;
    assign low_bit   = mask_reg & (~mask_reg + SLOT_N'(1));
    assign last_slot = (mask_reg & (mask_reg - SLOT_N'(1))) == '0;
    assign in_ready  = (mask_reg == '0) || (out_load && last_slot);
    assign take      = in_valid && in_ready;

    assign horiz_mean = mean_rgb(in_item.left, in_item.px);
    assign new_mask   = {1'b1, in_item.has_left, in_item.has_above,
                         in_item.has_above && in_item.has_left};

    always_comb
    begin
        if (mask_reg[0])
        begin
            sel_row = row2_reg - COORD_W'(1);
            sel_col = col2_reg - COORD_W'(1);
            sel_px  = corner_reg;
        end
        else if (mask_reg[1])
        begin
            sel_row = row2_reg - COORD_W'(1);
            sel_col = col2_reg;
            sel_px  = vert_reg;
        end
        else if (mask_reg[2])
        begin
            sel_row = row2_reg;
            sel_col = col2_reg - COORD_W'(1);
            sel_px  = horiz_reg;
        end
        else
        begin
            sel_row = row2_reg;
            sel_col = col2_reg;
            sel_px  = orig_reg;
        end
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (emit)
        begin
            mask_next = mask_reg & ~low_bit;
        end
        if (take)
        begin
            mask_next = new_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (out_load)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            corner_reg <= mean_rgb(mean_rgb(in_item.above_left, in_item.above), horiz_mean);
            vert_reg   <= mean_rgb(in_item.above, in_item.px);
            horiz_reg  <= horiz_mean;
            orig_reg   <= in_item.px;
            row2_reg   <= in_item.row2;
            col2_reg   <= in_item.col2;
        end
        if (emit)
        begin
            out_row_reg  <= sel_row;
            out_col_reg  <= sel_col;
            out_px_reg   <= sel_px;
            out_last_reg <= last_slot;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'b00, out_px_reg.blue, out_px_reg.green, out_px_reg.red,
                            out_col_reg, out_row_reg};

endmodule

// ----- sv/image_upscale_2x_interpolate.sv -----
// ----------------------------------------------------------------------------
// image_upscale_2x_interpolate
// Streaming 2x bilinear enlargement of RGB pixels in raster order.
//
//   Channel  Direction  Handshake                       Content
//   s_axis   in         s_axis_tvalid / s_axis_tready   input pixel, frame start
//   m_axis   out        m_axis_tvalid / m_axis_tready   output write, last flag
//   cfg      in         cfg_valid / cfg_ready           image width
//
// Each input item yields one to four writes, one per cycle from the output
// register while the output is not stalled.
// The line buffer is read in the cycle an item is accepted and written then unless
// the item is dropped; the read data reaches the interpolation stage in the next cycle.
// Reset clears counters and valid flags; the line buffer is not cleared.
// A stall on m_axis backs up through the interpolation stage to s_axis_tready.
// ----------------------------------------------------------------------------
module image_upscale_2x_interpolate
    import imgup2x_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [23:0]      s_axis_tdata,   // red, green, blue
    input  logic             s_axis_tuser,   // frame_start
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // out_row, out_column, red, green, blue
    output logic             m_axis_tlast,   // last_of_run
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data        // image_width
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WidthRst = (MAX_WIDTH < WIDTH_RST) ? MAX_WIDTH : WIDTH_RST;
    localparam logic [RW-1:0] RowMax = RW'(MAX_HEIGHT);
    localparam logic [CFG_WIDE_W-1:0] WideMax = CFG_WIDE_W'(MAX_WIDTH);

    logic [CW-1:0]         width_reg, width_next;
    logic [CW-1:0]         col_reg, col_next, pre_c, c_inc;
    logic [RW-1:0]         row_reg, row_next, pre_r;
    logic [CFG_WIDE_W-1:0] cfg_wide;
    rgb_t                  left_reg, above_left_reg, rd_reg, px, above;
    logic                  a_valid_reg;
    rgb_t                  a_px_reg, a_left_reg;
    coord_t                a_row2_reg, a_col2_reg;
    logic                  a_has_above_reg, a_has_left_reg;
    logic                  accept, drop, keep, a_move, b_ready;
    logic [AW-1:0]         addr;
    item_t                 item;

    rgb_t line_mem [MAX_WIDTH];

    assign cfg_ready = 1'b1;
    assign cfg_wide  = CFG_WIDE_W'(cfg_data);

    always_comb
    begin
        if (cfg_wide == '0)
        begin
            width_next = CW'(1);
        end
        else if (cfg_wide > WideMax)
        begin
            width_next = CW'(MAX_WIDTH);
        end
        else
        begin
            width_next = CW'(cfg_wide);
        end
    end

    assign px.red   = s_axis_tdata[7:0];
    assign px.green = s_axis_tdata[15:8];
    assign px.blue  = s_axis_tdata[23:16];

    assign a_move        = a_valid_reg && b_ready;
    assign s_axis_tready = !a_valid_reg || b_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // A shrunk width may leave the column past the row end; wrap before use.
    always_comb
    begin
        if (s_axis_tuser)
        begin
            pre_c = '0;
            pre_r = '0;
        end
        else if (col_reg >= width_reg)
        begin
            pre_c = '0;
            pre_r = (row_reg < RowMax) ? row_reg + RW'(1) : row_reg;
        end
        else
        begin
            pre_c = col_reg;
            pre_r = row_reg;
        end
    end

    assign drop  = (pre_r >= RowMax);
    assign keep  = accept && !drop;
    assign c_inc = pre_c + CW'(1);
    assign addr  = pre_c[AW-1:0];

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            col_next = pre_c;
            row_next = pre_r;
            if (!drop)
            begin
                if (c_inc >= width_reg)
                begin
                    col_next = '0;
                    row_next = pre_r + RW'(1);
                end
                else
                begin
                    col_next = c_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= CW'(WidthRst);
            col_reg        <= '0;
            row_reg        <= '0;
            left_reg       <= '0;
            above_left_reg <= '0;
            a_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                width_reg <= width_next;
            end
            col_reg <= col_next;
            row_reg <= row_next;
            if (keep)
            begin
                left_reg <= px;
            end
            if (a_move)
            begin
                above_left_reg <= above;
            end
            if (keep)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_move)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            a_px_reg        <= px;
            a_left_reg      <= left_reg;
            a_row2_reg      <= COORD_W'({pre_r, 1'b0});
            a_col2_reg      <= COORD_W'({pre_c, 1'b0});
            a_has_above_reg <= (pre_r != '0);
            a_has_left_reg  <= (pre_c != '0);
            line_mem[addr]  <= px;
        end
        if (accept)
        begin
            rd_reg <= line_mem[addr];
        end
    end

    assign above = a_has_above_reg ? rd_reg : '0;

    always_comb
    begin
        item.px         = a_px_reg;
        item.left       = a_left_reg;
        item.above_left = above_left_reg;
        item.above      = above;
        item.row2       = a_row2_reg;
        item.col2       = a_col2_reg;
        item.has_above  = a_has_above_reg;
        item.has_left   = a_has_left_reg;
    end

    imgup2x_interp u_interp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (a_valid_reg),
        .in_ready      (b_ready),
        .in_item       (item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
